>>> hw/rtl/olkd_pkg.sv
// Shared types and codes for the ordered key list.
// Used by olkd_cell and ordered_list_with_key_delete; no dependencies.
`default_nettype none

package olkd_pkg;

   localparam int KeyWidth = 32;

   typedef enum logic [2:0] {
      OP_INSERT    = 3'd0,
      OP_DEL_KEY   = 3'd1,
      OP_DEL_FIRST = 3'd2,
      OP_DEL_LAST  = 3'd3,
      OP_DUMP      = 3'd4
   } op_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [2:0]                 operation;
      logic signed [KeyWidth-1:0] key;
   } req_type;

   typedef struct packed {
      logic signed [KeyWidth-1:0] value;
      logic                       has_value;
      logic                       last;
      logic [1:0]                 status;
      logic [5:0]                 count;
   } rsp_type;

   // Broadcast command to every cell of the chain.
   typedef struct packed {
      logic                insert;
      logic                del_key;
      logic                del_first;
      logic                del_last;
      logic                rotate;
      logic [KeyWidth-1:0] key;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/ordered_list_with_key_delete.sv
// A status result is registered at the edge that accepts its request; a dump enters the
// dump state and registers its first element once the result register is free. Other
// requests finish at that accepting edge; a new request is taken whenever the result
// register is free. A dump rotates the chain once around, one element per cycle while
// the result register is free, and takes no request until its last element is out.
// Sync reset clears valid bits, count, state and result valid, not keys; uses olkd_cell.
`default_nettype none

module ordered_list_with_key_delete #(
   parameter int CAPACITY = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire olkd_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output olkd_pkg::rsp_type      rsp_payload
);

   localparam int CountWidth = $clog2(CAPACITY + 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(CAPACITY);
   localparam logic [CountWidth-1:0] OneCount  = CountWidth'(1);
   localparam int KW = olkd_pkg::KeyWidth;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic [CountWidth-1:0]   dump_left_ff, dump_left_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   olkd_pkg::rsp_type       rsp_payload_ff, rsp_payload_in;

   olkd_pkg::cell_cmd_type  cmd;
   logic [KW-1:0]           key_q [CAPACITY];
   logic [CAPACITY-1:0]     valid_vec;
   logic [CAPACITY:0]       hit_chain;

   logic                    accept, out_free, empty, full, found, dumping;
   logic [1:0]              status;
   logic [CountWidth+5:0]   count_wide;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dumping   = (state_ff == ST_DUMP);
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == FullCount);
   assign found     = hit_chain[CAPACITY];

   // Commands to the chain, only when the operation is legal on the current list.
   always_comb begin
      cmd           = '0;
      cmd.key       = req_payload.key;
      cmd.insert    = accept && (req_payload.operation == olkd_pkg::OP_INSERT) && !full;
      cmd.del_key   = accept && (req_payload.operation == olkd_pkg::OP_DEL_KEY);
      cmd.del_first = accept && (req_payload.operation == olkd_pkg::OP_DEL_FIRST) && !empty;
      cmd.del_last  = accept && (req_payload.operation == olkd_pkg::OP_DEL_LAST) && !empty;
      cmd.rotate    = dumping && out_free;
   end

   // The cell chain: cell 0 is the front of the list.
   assign hit_chain[0] = 1'b0;
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KW-1:0] lkey, rkey;
      logic          lvalid, rvalid;
      if (i == 0) begin : g_front
         assign lkey   = req_payload.key;
         assign lvalid = 1'b1;
      end else begin : g_mid
         assign lkey   = key_q[i-1];
         assign lvalid = valid_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_back
         assign rkey   = '0;
         assign rvalid = 1'b0;
      end else begin : g_inner
         assign rkey   = key_q[i+1];
         assign rvalid = valid_vec[i+1];
      end
      olkd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_key    (lkey),
         .left_valid  (lvalid),
         .right_key   (rkey),
         .right_valid (rvalid),
         .head_key    (key_q[0]),
         .hit_in      (hit_chain[i]),
         .hit_out     (hit_chain[i+1]),
         .key_q       (key_q[i]),
         .valid_q     (valid_vec[i])
      );
   end

   // Status and element count after the request.
   always_comb begin
      status   = olkd_pkg::STATUS_OK;
      count_in = count_ff;
      if (accept) begin
         case (req_payload.operation)
            olkd_pkg::OP_INSERT: begin
               if (full) status = olkd_pkg::STATUS_FULL;
               else      count_in = count_ff + OneCount;
            end
            olkd_pkg::OP_DEL_KEY: begin
               if (found) count_in = count_ff - OneCount;
               else       status = olkd_pkg::STATUS_NOT_FOUND;
            end
            olkd_pkg::OP_DEL_FIRST, olkd_pkg::OP_DEL_LAST: begin
               if (empty) status = olkd_pkg::STATUS_EMPTY;
               else       count_in = count_ff - OneCount;
            end
            default: begin
            end
         endcase
      end
   end

   // count field carries the low six bits
   assign count_wide = {6'd0, count_in};

   // Result register and dump sequencing.
   always_comb begin
      state_in       = state_ff;
      dump_left_in   = dump_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (dumping) begin
         if (out_free) begin
            rsp_valid_in             = 1'b1;
            rsp_payload_in.value     = signed'(key_q[0]);
            rsp_payload_in.has_value = 1'b1;
            rsp_payload_in.last      = (dump_left_ff == OneCount);
            rsp_payload_in.status    = olkd_pkg::STATUS_OK;
            rsp_payload_in.count     = count_wide[5:0];
            dump_left_in             = dump_left_ff - OneCount;
            if (dump_left_ff == OneCount) state_in = ST_IDLE;
         end
      end else if (accept) begin
         if ((req_payload.operation == olkd_pkg::OP_DUMP) && !empty) begin
            state_in     = ST_DUMP;
            dump_left_in = count_ff;
         end else begin
            rsp_valid_in             = 1'b1;
            rsp_payload_in.value     = '0;
            rsp_payload_in.has_value = 1'b0;
            rsp_payload_in.last      = 1'b1;
            rsp_payload_in.status    = status;
            rsp_payload_in.count     = count_wide[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      dump_left_ff   <= dump_left_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("element count above capacity");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("valid bits disagree with element count");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("valid cells are not packed at the front");

   a_dump_blocks_req: assert property (@(posedge clock) disable iff (reset)
      dumping |-> !req_ready)
      else $error("request taken during dump");

   a_dump_keeps_count: assert property (@(posedge clock) disable iff (reset)
      dumping |=> $stable(count_ff))
      else $error("count changed during dump");

endmodule

`default_nettype wire

>>> hw/rtl/olkd_cell.sv
// One storage cell of the key chain: a key, a valid bit, neighbor shifts.
// Depends on olkd_pkg.
`default_nettype none

module olkd_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire olkd_pkg::cell_cmd_type        cmd,
   input  wire logic [olkd_pkg::KeyWidth-1:0] left_key,
   input  wire logic                          left_valid,
   input  wire logic [olkd_pkg::KeyWidth-1:0] right_key,
   input  wire logic                          right_valid,
   input  wire logic [olkd_pkg::KeyWidth-1:0] head_key,
   input  wire logic                          hit_in,
   output logic                               hit_out,
   output logic [olkd_pkg::KeyWidth-1:0]      key_q,
   output logic                               valid_q
);

   logic [olkd_pkg::KeyWidth-1:0] key_ff, key_in;
   logic                          valid_ff, valid_in;
   logic                          match;
   logic                          is_tail;

   assign match   = cmd.del_key && valid_ff && (key_ff == cmd.key);
   assign hit_out = hit_in || match;
   assign is_tail = valid_ff && !right_valid;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         key_in   = left_key;
         valid_in = left_valid;
      end else if (cmd.del_first || (cmd.del_key && hit_out)) begin
         key_in   = right_key;
         valid_in = right_valid;
      end else if (cmd.del_last) begin
         if (is_tail) begin
            valid_in = 1'b0;
         end
      end else if (cmd.rotate) begin
         // tail wraps the front key around, everyone else moves forward
         key_in = is_tail ? head_key : right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign key_q   = key_ff;
   assign valid_q = valid_ff;

endmodule

`default_nettype wire

>>> sim/ordered_list_with_key_delete_checker.sv
`timescale 1ns / 100ps
// Checker for the ordered key list: keeps its own copy of the list, predicts each result
// and compares it field by field. Depends on olkd_pkg.
module ordered_list_with_key_delete_checker #(
   parameter int CAPACITY = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  olkd_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  olkd_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                open_rsp_count
);

   localparam int KeyWidth = olkd_pkg::KeyWidth;

   logic signed [KeyWidth-1:0] shadow_keys[$];
   olkd_pkg::rsp_type          expected_rsp[$];

   initial begin
      fail_count     = 0;
      open_rsp_count = 0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      fail_count++;
   endtask

   // Single status result with the count after the operation.
   function automatic olkd_pkg::rsp_type status_rsp(input logic [1:0] status);
      olkd_pkg::rsp_type r;
      r           = '0;
      r.last      = 1'b1;
      r.status    = status;
      r.count     = 6'(shadow_keys.size());
      return r;
   endfunction

   task automatic predict_list_op(input olkd_pkg::req_type r);
      int                hit;
      olkd_pkg::rsp_type d;
      hit = -1;
      case (r.operation)
         olkd_pkg::OP_INSERT: begin
            if (shadow_keys.size() >= CAPACITY) begin
               expected_rsp.push_back(status_rsp(olkd_pkg::STATUS_FULL));
            end else begin
               shadow_keys.push_front(r.key);
               expected_rsp.push_back(status_rsp(olkd_pkg::STATUS_OK));
            end
         end
         olkd_pkg::OP_DEL_KEY: begin
            foreach (shadow_keys[i])
               if (hit < 0 && shadow_keys[i] == r.key) hit = i;
            if (hit < 0) begin
               expected_rsp.push_back(status_rsp(olkd_pkg::STATUS_NOT_FOUND));
            end else begin
               shadow_keys.delete(hit);
               expected_rsp.push_back(status_rsp(olkd_pkg::STATUS_OK));
            end
         end
         olkd_pkg::OP_DEL_FIRST, olkd_pkg::OP_DEL_LAST: begin
            if (shadow_keys.size() == 0) begin
               expected_rsp.push_back(status_rsp(olkd_pkg::STATUS_EMPTY));
            end else begin
               if (r.operation == olkd_pkg::OP_DEL_FIRST) void'(shadow_keys.pop_front());
               else void'(shadow_keys.pop_back());
               expected_rsp.push_back(status_rsp(olkd_pkg::STATUS_OK));
            end
         end
         olkd_pkg::OP_DUMP: begin
            // empty list still answers once, with no value
            if (shadow_keys.size() == 0)
               expected_rsp.push_back(status_rsp(olkd_pkg::STATUS_OK));
            foreach (shadow_keys[i]) begin
               d           = '0;
               d.value     = shadow_keys[i];
               d.has_value = 1'b1;
               d.last      = (i == shadow_keys.size() - 1);
               d.status    = olkd_pkg::STATUS_OK;
               d.count     = 6'(shadow_keys.size());
               expected_rsp.push_back(d);
            end
         end
         default: expected_rsp.push_back(status_rsp(olkd_pkg::STATUS_OK));
      endcase
   endtask

   task automatic check_rsp(input olkd_pkg::rsp_type got);
      olkd_pkg::rsp_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected, value %0d", got.value));
      end else begin
         want = expected_rsp.pop_front();
         if (got.value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
         if (got.has_value !== want.has_value)
            report_mismatch($sformatf("has_value %0b, want %0b", got.has_value,
                                      want.has_value));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_keys.delete();
         expected_rsp.delete();
      end else begin
         if ($isunknown({req_ready, rsp_valid}))
            report_mismatch("handshake output unknown");
         // a result never belongs to the request taken at the same edge
         if (rsp_valid && rsp_ready) check_rsp(rsp_payload);
         if (req_valid && req_ready) predict_list_op(req_payload);
      end
      open_rsp_count = expected_rsp.size();
   end

endmodule

>>> sim/ordered_list_with_key_delete_tb.sv
`timescale 1ns / 100ps
// Top of the ordered key list testbench: clock, reset, request stimulus, result back-pressure
// and the verdict. Depends on olkd_pkg, the block and ordered_list_with_key_delete_checker.
module ordered_list_with_key_delete_tb;

   localparam int CAPACITY    = 32;
   localparam int KeyWidth    = olkd_pkg::KeyWidth;
   localparam int ClockPeriod = 12;
   localparam int ResetCycles = 7;
   // about 120 requests, each at worst a full dump under result stalls
   localparam int CycleLimit  = 300000;
   localparam int HoldCycles  = 80;   // long result hold-off, fills the block
   localparam int DrainCycles = 50;   // covers a full-list dump after the last result
   localparam int RandomItems = 120;
   localparam int TailItems   = 20;   // requests sent without idling at the end

   // operation codes the block does not use
   localparam logic [2:0] OpSpareLo  = 3'd5;
   localparam logic [2:0] OpSpareMid = 3'd6;
   localparam logic [2:0] OpSpareHi  = 3'd7;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   olkd_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   olkd_pkg::rsp_type rsp_payload;

   int fail_count;
   int open_rsp_count;
   int cycle_count = 0;
   int items_sent;
   int gap_odds;        // one gap per gap_odds requests, on average
   bit quiet_phase;     // no idling on either side
   bit hold_off_wanted; // stimulus asks the receiver for the long hold-off
   bit hold_off_taken;

   ordered_list_with_key_delete #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   ordered_list_with_key_delete_checker #(
      .CAPACITY(CAPACITY)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .open_rsp_count(open_rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Keys: half from a tiny range around zero so deletes by key hit often and
   // duplicates show up, half from the full 32-bit space.
   function automatic logic [KeyWidth-1:0] pick_key();
      if ($urandom_range(0, 1) == 0) return KeyWidth'($urandom_range(0, 7)) - 4;
      return $urandom();
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance, or later if a gap is drawn.
   // Valid stays high into the next request unless a gap is drawn.
   task automatic send_op(input logic [2:0] op, input logic [KeyWidth-1:0] key);
      olkd_pkg::req_type r;
      r.operation = op;
      r.key       = key;
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (!quiet_phase && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   // Enough inserts to reach full from any state and overflow, then show it.
   task automatic fill_list();
      repeat (CAPACITY + 2) send_op(olkd_pkg::OP_INSERT, pick_key());
      send_op(olkd_pkg::OP_DUMP, pick_key());
   endtask

   // Empty from any state from both ends, plus deletes on the empty list.
   task automatic drain_list();
      repeat (CAPACITY + 2)
         send_op($urandom_range(0, 1) ? olkd_pkg::OP_DEL_FIRST : olkd_pkg::OP_DEL_LAST,
                 pick_key());
      send_op(olkd_pkg::OP_DUMP, pick_key());
   endtask

   // Random mix of all operations, unused codes now and then.
   task automatic mix_ops(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      send_op(olkd_pkg::OP_INSERT, pick_key());
         else if (pick < 55) send_op(olkd_pkg::OP_DEL_KEY, pick_key());
         else if (pick < 68) send_op(olkd_pkg::OP_DEL_FIRST, pick_key());
         else if (pick < 81) send_op(olkd_pkg::OP_DEL_LAST, pick_key());
         else if (pick < 93) send_op(olkd_pkg::OP_DUMP, pick_key());
         else                send_op(3'($urandom_range(OpSpareLo, OpSpareHi)), pick_key());
      end
   endtask

   // Request side and verdict.
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_payload     = '0;
      items_sent      = 0;
      gap_odds        = 4;
      quiet_phase     = 1'b0;
      hold_off_wanted = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every op on the empty list, extreme keys, delete in the
      // middle and at the front, duplicates, unused codes, back to empty.
      send_op(olkd_pkg::OP_DUMP, 32'd0);
      send_op(olkd_pkg::OP_DEL_FIRST, 32'd0);
      send_op(olkd_pkg::OP_DEL_LAST, 32'd0);
      send_op(olkd_pkg::OP_DEL_KEY, 32'd0);
      send_op(olkd_pkg::OP_INSERT, 32'h7FFF_FFFF);
      send_op(olkd_pkg::OP_INSERT, 32'h8000_0000);
      send_op(olkd_pkg::OP_INSERT, 32'd0);
      send_op(olkd_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_op(olkd_pkg::OP_DUMP, 32'd0);
      send_op(olkd_pkg::OP_DEL_KEY, 32'd5);          // absent
      send_op(olkd_pkg::OP_DEL_KEY, 32'd0);          // middle element
      send_op(olkd_pkg::OP_INSERT, 32'hFFFF_FFFF);   // duplicate at the front
      send_op(olkd_pkg::OP_DEL_KEY, 32'hFFFF_FFFF);  // only the front-most goes
      send_op(olkd_pkg::OP_DUMP, 32'd0);
      send_op(OpSpareLo, 32'd0);
      send_op(OpSpareMid, 32'h7FFF_FFFF);
      send_op(OpSpareHi, 32'hFFFF_FFFF);
      send_op(olkd_pkg::OP_DEL_FIRST, 32'd0);
      send_op(olkd_pkg::OP_DEL_LAST, 32'd0);
      send_op(olkd_pkg::OP_DUMP, 32'd0);
      send_op(olkd_pkg::OP_DEL_KEY, 32'h8000_0000);  // last element goes by key
      send_op(olkd_pkg::OP_DUMP, 32'd0);

      // First fill runs under the long result hold-off, so the block backs
      // up and stalls requests while the sender keeps offering.
      hold_off_wanted = 1'b1;
      gap_odds        = 8;
      fill_list();
      drain_list();

      while (items_sent < RandomItems - TailItems) begin
         gap_odds = $urandom_range(0, 3) == 0 ? 1000 : $urandom_range(2, 8);
         mix_ops(4);
      end

      // Tail without idling on either side.
      quiet_phase = 1'b1;
      mix_ops(TailItems);
      req_valid <= 1'b0;

      while (open_rsp_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (fail_count == 0 && open_rsp_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Result side: random ready bursts, one long hold-off on request.
   initial begin
      rsp_ready      = 1'b0;
      hold_off_taken = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_wanted && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end else if (quiet_phase) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
      end
   end

endmodule
